// ===== src/lstb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lstb_pkg;

    // Fixed field widths of the item channels
    localparam int LCP_W = 16;
    localparam int IDX_W = 16;
    localparam int TGT_W = 17;

    // One stack entry: pending index and its LCP value
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [LCP_W-1:0] lcp;
    } t_entry;

endpackage

`default_nettype wire

// ===== src/lstb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lstb_in_if import lstb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LCP_W-1:0] lcp_value;
    logic             is_last;

    modport source (output valid, output lcp_value, output is_last, input ready);
    modport sink   (input valid, input lcp_value, input is_last, output ready);
endinterface

`default_nettype wire

// ===== src/lstb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lstb_out_if import lstb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] entry_index;
    logic [TGT_W-1:0] skip_target;
    logic             run_end;
    logic             overflow;

    modport source (output valid, output entry_index, output skip_target,
                    output run_end, output overflow, input ready);
    modport sink   (input valid, input entry_index, input skip_target,
                    input run_end, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/lstb_stack_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stack storage: one write port, one read port with registered data
module lstb_stack_ram import lstb_pkg::*; #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/lcp_skip_table_builder_top.sv =====
// Input: an item is accepted only in the idle state, so a new LCP value waits until the previous
//   one has finished its pops and push; at position 0 or past the length limit no stack work is done.
// Last item: every remaining entry is flushed, followed by the final (0, total) entry.
// Pace is set by the stack RAM read latency and the single compare in the pop loop.
// Results leave through an output register; stalls there hold the sequencer.
// Synchronous active-low reset empties the stack and clears position and overflow.
`timescale 1ns / 1ps
`default_nettype none

module lcp_skip_table_builder_top import lstb_pkg::*; #(
    parameter longint MAX_LEN     = 65536,
    parameter int     STACK_DEPTH = 63,
    parameter int     LCP_WIDTH   = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lstb_in_if.sink     i_in,
    lstb_out_if.source  o_out
);

    localparam int PW_RAW = $clog2(MAX_LEN + 1);
    localparam int PW     = (PW_RAW > TGT_W) ? PW_RAW : TGT_W;
    localparam int TW     = $clog2(STACK_DEPTH + 1);
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);
    localparam logic [LCP_W-1:0] LCP_MAX = (LCP_WIDTH >= LCP_W) ? {LCP_W{1'b1}} :
                                           LCP_W'((64'd1 << LCP_WIDTH) - 64'd1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_END  = 3'd3;
    localparam logic [2:0] S_FL   = 3'd4;
    localparam logic [2:0] S_FLE  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [TW-1:0]    r_top, n_top;
    logic [PW-1:0]    r_pos, n_pos;
    logic             r_ovf, n_ovf;
    logic             r_last, n_last;
    logic [LCP_W-1:0] r_v, n_v;
    logic [IDX_W-1:0] r_hold, n_hold;
    logic             r_have, n_have;

    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [TGT_W-1:0] r_out_tgt, n_out_tgt;
    logic             r_out_end, n_out_end;
    logic             r_out_ovf, n_out_ovf;

    logic             ram_we, ram_re;
    t_entry           ram_wdata, ram_rdata;
    logic [AW-1:0]    ram_raddr;
    logic             out_free;
    logic [LCP_W-1:0] sat_v;

    lstb_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_top[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign sat_v     = (i_in.lcp_value > LCP_MAX) ? LCP_MAX : i_in.lcp_value;
    assign ram_wdata = '{idx: r_pos[IDX_W-1:0], lcp: r_v};
    assign ram_raddr = AW'(r_top - TW'(1));
    assign out_free  = !r_out_valid || o_out.ready;

    // sequencer: pop loop with one pop of lookahead, push, flush
    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_v         = r_v;
        n_hold      = r_hold;
        n_have      = r_have;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_idx   = r_out_idx;
        n_out_tgt   = r_out_tgt;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_v    = sat_v;
                    n_last = i_in.is_last;
                    n_have = 1'b0;
                    if (r_pos >= MAX_POS) begin
                        n_ovf   = 1'b1;
                        n_state = i_in.is_last ? S_FL : S_IDLE;
                    end else if (r_pos == '0) begin
                        n_pos   = PW'(1);
                        n_state = i_in.is_last ? S_FL : S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_top == '0) begin
                    n_state = S_END;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (ram_rdata.lcp > r_v) begin
                    if (!r_have || out_free) begin
                        // another pop follows, so the held one is not the run end
                        if (r_have) begin
                            n_out_valid = 1'b1;
                            n_out_idx   = r_hold;
                            n_out_tgt   = r_pos[TGT_W-1:0];
                            n_out_end   = 1'b0;
                            n_out_ovf   = r_ovf;
                        end
                        n_hold  = ram_rdata.idx;
                        n_have  = 1'b1;
                        n_top   = r_top - TW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (!r_have || out_free) begin
                    if (r_have) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = r_hold;
                        n_out_tgt   = r_pos[TGT_W-1:0];
                        n_out_end   = !r_last;
                        n_out_ovf   = r_ovf;
                    end
                    n_have = 1'b0;
                    // push; one slot stays reserved for the last element
                    if (r_last || (r_top < TW'(STACK_DEPTH - 1))) begin
                        ram_we = 1'b1;
                        n_top  = r_top + TW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_pos   = r_pos + PW'(1);
                    n_state = r_last ? S_FL : S_IDLE;
                end
            end
            S_FL: begin
                if (r_top == '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = '0;
                        n_out_tgt   = r_pos[TGT_W-1:0];
                        n_out_end   = 1'b1;
                        n_out_ovf   = r_ovf;
                        n_pos       = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_FLE;
                end
            end
            S_FLE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = ram_rdata.idx;
                    n_out_tgt   = r_pos[TGT_W-1:0];
                    n_out_end   = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_top       = r_top - TW'(1);
                    n_state     = S_FL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_pos       <= n_pos;
            r_ovf       <= n_ovf;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_v       <= n_v;
        r_hold    <= n_hold;
        r_out_idx <= n_out_idx;
        r_out_tgt <= n_out_tgt;
        r_out_end <= n_out_end;
        r_out_ovf <= n_out_ovf;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.entry_index = r_out_idx;
    assign o_out.skip_target = r_out_tgt;
    assign o_out.run_end     = r_out_end;
    assign o_out.overflow    = r_out_ovf;

endmodule

`default_nettype wire

// ===== tb/sv/lcp_skip_table_builder_top_tb.sv =====
`timescale 1ns / 1ps

module lcp_skip_table_builder_top_tb;
    import lstb_pkg::*;

    localparam longint MAX_SEQ_LEN = 65536;
    localparam int     STACK_DEPTH = 63;
    localparam int     LCP_WIDTH   = 16;
    localparam longint LCP_CAP     = (64'd1 << LCP_WIDTH) - 1;
    localparam int     DRAIN_CYCLES = 300;

    // One LCP value to send; hold makes the sender wait until all skips are out
    typedef struct {
        logic [LCP_W-1:0] lcp;
        logic             is_last;
        bit               hold;
    } lcp_item_t;

    // One skip table entry as the block reports it
    typedef struct {
        logic [IDX_W-1:0] entry_index;
        logic [TGT_W-1:0] skip_target;
        logic             run_end;
        logic             overflow;
    } skip_entry_t;

    logic i_clk;
    logic i_rst_n;

    lstb_in_if  in_if ();
    lstb_out_if out_if ();

    lcp_skip_table_builder_top #(
        .MAX_LEN    (MAX_SEQ_LEN),
        .STACK_DEPTH(STACK_DEPTH),
        .LCP_WIDTH  (LCP_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    lcp_item_t   pending_items[$];
    skip_entry_t expected_skips[$];
    lcp_item_t   cur_item;
    logic        offer;

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int values_sent;
    int seqs_sent;
    int skips_checked;

    // Shadow of the monotonic stack
    logic [IDX_W-1:0] stk_idx [STACK_DEPTH];
    longint           stk_lcp [STACK_DEPTH];
    int               stk_depth;
    longint           seq_pos;
    bit               ovf_seen;

    // Clock and reset
    always #10 i_clk = ~i_clk;

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.lcp_value = '0;
        in_if.is_last   = 1'b0;
        out_if.ready    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Work out the skip entries that one accepted LCP value releases
    task automatic predict_skips(input logic [LCP_W-1:0] lcp_in, input logic last_in);
        longint      v;
        longint      p;
        skip_entry_t found[$];
        skip_entry_t r;
        v = longint'(lcp_in);
        r.run_end  = 1'b0;
        r.overflow = 1'b0;
        if (v > LCP_CAP) v = LCP_CAP;
        if (seq_pos >= MAX_SEQ_LEN) begin
            // past the length limit: value ignored
            ovf_seen = 1'b1;
        end else begin
            p = seq_pos;
            if (p != 0) begin
                // pop every strictly greater entry, equal ones stay
                while (stk_depth > 0 && stk_lcp[stk_depth-1] > v) begin
                    stk_depth--;
                    r.entry_index = stk_idx[stk_depth];
                    r.skip_target = TGT_W'(p);
                    found.push_back(r);
                end
                // one slot is reserved for the last element
                if ((last_in || stk_depth < STACK_DEPTH - 1) && stk_depth < STACK_DEPTH) begin
                    stk_idx[stk_depth] = IDX_W'(p);
                    stk_lcp[stk_depth] = v;
                    stk_depth++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            seq_pos = p + 1;
        end
        if (last_in) begin
            // flush top-down with the total count, then index zero
            while (stk_depth > 0) begin
                stk_depth--;
                r.entry_index = stk_idx[stk_depth];
                r.skip_target = TGT_W'(seq_pos);
                found.push_back(r);
            end
            r.entry_index = '0;
            r.skip_target = TGT_W'(seq_pos);
            found.push_back(r);
            stk_depth = 0;
            seq_pos   = 0;
        end
        foreach (found[k]) begin
            found[k].overflow = ovf_seen;
            found[k].run_end  = (k == found.size() - 1);
            expected_skips.push_back(found[k]);
        end
    endtask

    task automatic queue_lcp(input longint v, input bit last_in, input bit hold = 1'b0);
        lcp_item_t it;
        it.lcp     = LCP_W'(v);
        it.is_last = last_in;
        it.hold    = hold;
        pending_items.push_back(it);
    endtask

    // Random sequence: full range, narrow range (ties and pops), or extremes
    task automatic queue_random_seq(input int len);
        int     mode;
        longint v;
        mode = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: begin
                    v = longint'($urandom_range(65535));
                end
                1: begin
                    v = longint'($urandom_range(3));
                end
                default: begin
                    case ($urandom_range(2))
                        0:       v = 0;
                        1:       v = 65535;
                        default: v = longint'($urandom_range(65535));
                    endcase
                end
            endcase
            queue_lcp(v, i == len - 1);
        end
    endtask

    task automatic queue_random_items(input int count);
        int n;
        n = 0;
        while (n < count) begin
            queue_random_seq($urandom_range(1, 12));
            n = pending_items.size();
        end
    endtask

    // Nondecreasing run of 63 to 68 values; runs of 65 or more fill the stack and drop pushes
    task automatic queue_ramp();
        int     len;
        longint v;
        len = $urandom_range(63, 68);
        v   = longint'($urandom_range(1000));
        for (int i = 0; i < len; i++) begin
            v = v + longint'($urandom_range(3));
            queue_lcp(v, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_if.valid || expected_skips.size() != 0);
    endtask

    // Driver: predicts on each accepted transfer, then offers the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            offer = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                predict_skips(cur_item.lcp, cur_item.is_last);
                values_sent++;
                if (cur_item.is_last) seqs_sent++;
                offer = 1'b0;
            end
            if (!offer && pending_items.size() != 0 &&
                $urandom_range(99) >= send_idle_pct &&
                !(pending_items[0].hold && expected_skips.size() != 0)) begin
                cur_item = pending_items.pop_front();
                offer    = 1'b1;
                in_if.lcp_value <= cur_item.lcp;
                in_if.is_last   <= cur_item.is_last;
            end
            in_if.valid <= offer;
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        skip_entry_t exp_e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_skips.size() == 0) begin
                    $error("unexpected skip entry: index %0d target %0d",
                           out_if.entry_index, out_if.skip_target);
                    errors++;
                end else begin
                    exp_e = expected_skips.pop_front();
                    skips_checked++;
                    if (out_if.entry_index !== exp_e.entry_index) begin
                        $error("entry_index: expected %0d, got %0d",
                               exp_e.entry_index, out_if.entry_index);
                        errors++;
                    end
                    if (out_if.skip_target !== exp_e.skip_target) begin
                        $error("skip_target: expected %0d, got %0d",
                               exp_e.skip_target, out_if.skip_target);
                        errors++;
                    end
                    if (out_if.run_end !== exp_e.run_end) begin
                        $error("run_end: expected %0b, got %0b",
                               exp_e.run_end, out_if.run_end);
                        errors++;
                    end
                    if (out_if.overflow !== exp_e.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               exp_e.overflow, out_if.overflow);
                        errors++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus phases
    initial begin
        errors        = 0;
        values_sent   = 0;
        seqs_sent     = 0;
        skips_checked = 0;
        stk_depth     = 0;
        seq_pos       = 0;
        ovf_seen      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 79;

        // single element, first and last at once
        queue_lcp(65535, 1'b1);
        // index zero value ignored, ties kept, extremes popped by zero
        queue_lcp(0, 1'b0);
        queue_lcp(65535, 1'b0);
        queue_lcp(65535, 1'b0);
        queue_lcp(0, 1'b0);
        queue_lcp(65535, 1'b1);
        // mixed pops, ending with a value that drains everything
        queue_lcp(7, 1'b0);
        queue_lcp(3, 1'b0);
        queue_lcp(5, 1'b0);
        queue_lcp(5, 1'b0, 1'b1);
        queue_lcp(1, 1'b0);
        queue_lcp(0, 1'b1);
        // strictly descending: each item from the third pops one entry
        queue_lcp(100, 1'b0);
        queue_lcp(50, 1'b0);
        queue_lcp(40, 1'b0);
        queue_lcp(30, 1'b0);
        queue_lcp(20, 1'b0);
        queue_lcp(10, 1'b1);
        // two zeros
        queue_lcp(0, 1'b0);
        queue_lcp(0, 1'b1);
        wait_drained();

        // sender mostly busy, receiver mostly stalled
        @(negedge i_clk);
        queue_random_items(50);
        pending_items[pending_items.size() / 2].hold = 1'b1;
        wait_drained();

        // sender mostly idle, receiver mostly ready; ends with a nondecreasing ramp
        send_idle_pct = 79;
        recv_idle_pct = 19;
        queue_random_items(40);
        pending_items[pending_items.size() / 3].hold = 1'b1;
        queue_ramp();
        wait_drained();

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_items(30);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d LCP values in %0d sequences, checked %0d skip entries.",
                 values_sent, seqs_sent, skips_checked);
        $display("Covered ties, full-stack drops, single-item runs and three pacing mixes.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd50_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
